// ===== src/analog_button_event_detector_macros.svh =====
// ----------------------------------------------------------------------------
// Analog button event detector assertion macros
// Concurrent check helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ANALOG_BUTTON_EVENT_DETECTOR_MACROS_SVH
`define ANALOG_BUTTON_EVENT_DETECTOR_MACROS_SVH

// same-cycle implication
`define ABED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ABED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/abed_pkg.sv =====
// ----------------------------------------------------------------------------
// Analog button event detector package
// Payload, configuration and state types, register indexes, reset values.
// ----------------------------------------------------------------------------
package abed_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_TARGET     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_TOLERANCE  = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_DELAY_MS    = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POLL_INTERVAL_MS = 4'd3;

    localparam logic [SAMPLE_BITS-1:0] RST_LEVEL_TARGET     = SAMPLE_BITS'(512);
    localparam logic [SAMPLE_BITS-1:0] RST_LEVEL_TOLERANCE  = SAMPLE_BITS'(20);
    localparam logic [15:0]            RST_HOLD_DELAY_MS    = 16'd500;
    localparam logic [7:0]             RST_POLL_INTERVAL_MS = 8'd10;

    typedef struct packed {
        logic [31:0]            now_ms;
        logic [SAMPLE_BITS-1:0] sample;
    } abed_in_t;

    typedef struct packed {
        logic sampled;
        logic pressed_level;
        logic press_event;
        logic hold_event;
        logic release_event;
        logic click_event;
    } abed_out_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level_target;
        logic [SAMPLE_BITS-1:0] level_tolerance;
        logic [15:0]            hold_delay_ms;
        logic [7:0]             poll_interval_ms;
    } abed_cfg_t;

    typedef struct packed {
        logic [31:0] poll_deadline;
        logic [31:0] hold_deadline;
        logic        pressed_now;
        logic        was_pressed;
        logic        hold_done;
    } abed_state_t;

endpackage

// ===== src/abed_step.sv =====
// ----------------------------------------------------------------------------
// Analog button event detector step logic
// Window check, deadline update and event decode for one item.
// ----------------------------------------------------------------------------
module abed_step (
    input  abed_pkg::abed_cfg_t   cfg,
    input  abed_pkg::abed_state_t state,
    input  abed_pkg::abed_in_t    item,
    output abed_pkg::abed_state_t state_next,
    output abed_pkg::abed_out_t   result
);

    localparam int WIN_BITS = abed_pkg::SAMPLE_BITS + 2;

    logic signed [WIN_BITS-1:0] smp;
    logic signed [WIN_BITS-1:0] win_lo;
    logic signed [WIN_BITS-1:0] win_hi;
    logic                       poll_hit;
    logic                       in_window;

    assign smp    = $signed({2'b00, item.sample});
    assign win_lo = $signed({2'b00, cfg.level_target}) - $signed({2'b00, cfg.level_tolerance});
    assign win_hi = $signed({2'b00, cfg.level_target}) + $signed({2'b00, cfg.level_tolerance});
    assign poll_hit  = state.poll_deadline < item.now_ms;
    assign in_window = (smp > win_lo) && (smp < win_hi);

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (poll_hit)
        begin
            result.sampled = 1'b1;
            if (in_window)
            begin
                state_next.pressed_now = 1'b1;
                if (!state.was_pressed)
                begin
                    result.press_event     = 1'b1;
                    state_next.was_pressed = 1'b1;
                    state_next.hold_done   = 1'b0;
                end
                if (state.hold_deadline != 32'd0)
                begin
                    if (!state_next.hold_done && (state.hold_deadline < item.now_ms))
                    begin
                        state_next.hold_deadline = 32'd0;
                        result.hold_event        = 1'b1;
                        state_next.hold_done     = 1'b1;
                    end
                end
                else if (!state_next.hold_done)
                begin
                    state_next.hold_deadline = item.now_ms + {16'd0, cfg.hold_delay_ms};
                end
            end
            else
            begin
                state_next.pressed_now = 1'b0;
                if (state.was_pressed)
                begin
                    result.release_event   = 1'b1;
                    state_next.was_pressed = 1'b0;
                    if (state.hold_deadline != 32'd0)
                    begin
                        state_next.hold_deadline = 32'd0;
                        result.click_event       = 1'b1;
                    end
                end
            end
            state_next.poll_deadline = item.now_ms + {24'd0, cfg.poll_interval_ms};
        end
        result.pressed_level = state_next.pressed_now;
    end

endmodule

// ===== src/analog_button_event_detector.sv =====
// ----------------------------------------------------------------------------
// Analog button event detector
// Each accepted item passes through the input register, then the result
// register, to out_item. One item per cycle while out_ready does not stall it.
// Reset: all state, deadlines and valid flags clear; configuration registers
// load their default levels and delays. No clearing pass.
// ----------------------------------------------------------------------------
`include "analog_button_event_detector_macros.svh"

module analog_button_event_detector (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  abed_pkg::abed_in_t                      in_item,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output abed_pkg::abed_out_t                     out_item,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [abed_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [abed_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    abed_pkg::abed_cfg_t   cfg_reg;
    abed_pkg::abed_state_t state_reg;
    abed_pkg::abed_state_t state_next;
    abed_pkg::abed_in_t    item_reg;
    abed_pkg::abed_out_t   result_next;
    abed_pkg::abed_out_t   result_reg;
    logic                  item_valid_reg;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  advance;

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = item_valid_reg && out_free;
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = result_reg;

    abed_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_target     <= abed_pkg::RST_LEVEL_TARGET;
            cfg_reg.level_tolerance  <= abed_pkg::RST_LEVEL_TOLERANCE;
            cfg_reg.hold_delay_ms    <= abed_pkg::RST_HOLD_DELAY_MS;
            cfg_reg.poll_interval_ms <= abed_pkg::RST_POLL_INTERVAL_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                abed_pkg::REG_LEVEL_TARGET:
                    cfg_reg.level_target <= cfg_data[abed_pkg::SAMPLE_BITS-1:0];
                abed_pkg::REG_LEVEL_TOLERANCE:
                    cfg_reg.level_tolerance <= cfg_data[abed_pkg::SAMPLE_BITS-1:0];
                abed_pkg::REG_HOLD_DELAY_MS:
                    cfg_reg.hold_delay_ms <= cfg_data[15:0];
                abed_pkg::REG_POLL_INTERVAL_MS:
                    cfg_reg.poll_interval_ms <= cfg_data[7:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `ABED_ASSERT_NOW(a_event_needs_sample, out_valid_reg && (result_reg.press_event || result_reg.hold_event || result_reg.release_event || result_reg.click_event), result_reg.sampled, "event flag on an item without a sample check")
    `ABED_ASSERT_NOW(a_click_needs_release, out_valid_reg && result_reg.click_event, result_reg.release_event && !result_reg.pressed_level, "click without release")
    `ABED_ASSERT_NOW(a_hold_armed_when_pressed, state_reg.hold_deadline != 32'd0, state_reg.was_pressed && !state_reg.hold_done, "hold deadline armed outside a press")
    `ABED_ASSERT_NEXT(a_result_on_advance, advance, out_valid_reg, "advanced item did not reach the result register")

endmodule
